/* sv/hksl_pkg.sv */
// ============================================================================
// hksl_pkg: shared types and constants of the hashed key set
// Table geometry, hash constants, load limit, controller state and the
// command/status bundles between controller and datapath.
// ============================================================================
package hksl_pkg;

    // Table geometry (power of two)
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;

    // An absent key is refused when (count + 1) * 10 >= TABLE_SLOTS * 7,
    // i.e. when count >= ceil(TABLE_SLOTS * 7 / 10) - 1.
    localparam int LOAD_LIMIT  = (TABLE_SLOTS * 7 + 9) / 10;
    localparam int FULL_COUNT  = LOAD_LIMIT - 1;

    // Key and half-key widths
    localparam int KEY_W       = 64;
    localparam int HALF_W      = 32;

    // Mixing hash constants
    localparam logic [63:0] HASH_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] HASH_FMIX   = 64'hbf58_476d_1ce4_e5b9;
    localparam int          SHIFT_MIX   = 30;
    localparam int          SHIFT_FIN_A = 27;
    localparam int          SHIFT_FIN_B = 31;

    // Result bit positions in m_tdata
    localparam int RES_PRESENT  = 0;
    localparam int RES_INSERTED = 1;
    localparam int RES_REJECT   = 2;
    localparam int RES_BITS     = 3;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_H1_LL,
        ST_H1_HL,
        ST_H1_LH,
        ST_MIX,
        ST_H2_LL,
        ST_H2_HL,
        ST_H2_LH,
        ST_HOME,
        ST_READ,
        ST_CHECK
    } hksl_state_t;

    // Hash datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL_LL,
        OP_MUL_HL,
        OP_MUL_LH,
        OP_MIX,
        OP_HOME
    } hksl_op_t;

    // Controller -> datapath
    typedef struct packed {
        logic     load;
        logic     clear;
        hksl_op_t op;
        logic     mul_fmix;
        logic     rd;
        logic     step;
        logic     finish;
    } hksl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic hit;
        logic empty;
        logic last;
        logic out_free;
    } hksl_stat_t;

endpackage

/* sv/hksl_datapath.sv */
// ============================================================================
// hksl_datapath: hash unit, slot memories and result register
// Computes the home slot with one shared 32x32 multiplier, reads and writes
// the key and occupancy memories, and holds the result for the m_ side.
// ============================================================================
module hksl_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [127:0]       s_tdata,
    input  logic               s_tuser,
    input  hksl_pkg::hksl_cmd_t  cmd,
    output hksl_pkg::hksl_stat_t stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata
);
    import hksl_pkg::*;

    // Key and occupancy memories
    logic [2*KEY_W-1:0] key_mem  [TABLE_SLOTS];
    logic               used_mem [TABLE_SLOTS];

    // Request registers
    logic               req_reg;
    logic [KEY_W-1:0]   dev_reg;
    logic [KEY_W-1:0]   ino_reg;

    // Hash registers
    logic [KEY_W-1:0]   op_reg;
    logic [KEY_W-1:0]   acc_reg;

    // Probe registers
    logic [SLOT_W-1:0]  idx_reg;
    logic [SLOT_W-1:0]  pcnt_reg;
    logic [SLOT_W-1:0]  clr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               rd_used_reg;
    logic [2*KEY_W-1:0] rd_key_reg;

    // Result register
    logic               out_valid_reg;
    logic [RES_BITS-1:0] out_data_reg;

    // Hash combinational
    logic [HALF_W-1:0]  mul_a;
    logic [HALF_W-1:0]  mul_b;
    logic [KEY_W-1:0]   const_w;
    logic [KEY_W-1:0]   prod;
    logic [KEY_W-1:0]   mix_x;
    logic [KEY_W-1:0]   mix_y;
    logic [KEY_W-1:0]   fin_a;
    logic [KEY_W-1:0]   fin_b;

    // Probe decision
    logic               hit;
    logic               at_limit;
    logic               do_ins;
    logic               do_rej;
    logic               ins_we;

    // Shared multiplier operand selection
    always_comb begin
        const_w = cmd.mul_fmix ? HASH_FMIX : HASH_GOLDEN;
        mul_a   = (cmd.op == OP_MUL_HL) ? op_reg[KEY_W-1:HALF_W] : op_reg[HALF_W-1:0];
        mul_b   = (cmd.op == OP_MUL_LH) ? const_w[KEY_W-1:HALF_W] : const_w[HALF_W-1:0];
        prod    = KEY_W'(mul_a) * KEY_W'(mul_b);
    end

    // Xor-shift steps
    always_comb begin
        mix_x = acc_reg ^ ino_reg;
        mix_y = mix_x ^ (mix_x >> SHIFT_MIX);
        fin_a = acc_reg ^ (acc_reg >> SHIFT_FIN_A);
        fin_b = fin_a ^ (fin_a >> SHIFT_FIN_B);
    end

    // Slot check and insert decision
    always_comb begin
        hit      = rd_used_reg && (rd_key_reg[KEY_W-1:0] == dev_reg)
                   && (rd_key_reg[2*KEY_W-1:KEY_W] == ino_reg);
        at_limit = count_reg >= CNT_W'(FULL_COUNT);
        do_ins   = req_reg && !hit && !rd_used_reg && !at_limit;
        do_rej   = req_reg && !hit && !do_ins;
        ins_we   = cmd.finish && do_ins;
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_tuser;
            dev_reg <= s_tdata[KEY_W-1:0];
            ino_reg <= s_tdata[2*KEY_W-1:KEY_W];
        end
    end

    // Hash sequence: low 64 bits of a 64x64 product in three partial products
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_MUL_LL: acc_reg <= prod;
            OP_MUL_HL: acc_reg <= acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
            OP_MUL_LH: acc_reg <= acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
            default:   acc_reg <= acc_reg;
        endcase
        if (cmd.load) begin
            op_reg <= s_tdata[KEY_W-1:0];
        end else if (cmd.op == OP_MIX) begin
            op_reg <= mix_y;
        end
    end

    // Probe index and visit count
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_HOME) begin
            idx_reg  <= fin_b[SLOT_W-1:0];
            pcnt_reg <= '0;
        end else if (cmd.step) begin
            idx_reg  <= idx_reg + 1'b1;
            pcnt_reg <= pcnt_reg + 1'b1;
        end
    end

    // Clear sweep counter and entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.clear) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ins_we) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Occupancy memory
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            used_mem[clr_reg] <= 1'b0;
        end else if (ins_we) begin
            used_mem[idx_reg] <= 1'b1;
        end
        if (cmd.rd) begin
            rd_used_reg <= used_mem[idx_reg];
        end
    end

    // Key memory: inode in the upper half, device in the lower
    always_ff @(posedge aclk) begin
        if (ins_we) begin
            key_mem[idx_reg] <= {ino_reg, dev_reg};
        end
        if (cmd.rd) begin
            rd_key_reg <= key_mem[idx_reg];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg[RES_PRESENT]  <= hit;
            out_data_reg[RES_INSERTED] <= do_ins;
            out_data_reg[RES_REJECT]   <= do_rej;
        end
    end

    // Status to controller
    always_comb begin
        stat.clear_last = (clr_reg == SLOT_W'(TABLE_SLOTS - 1));
        stat.hit        = hit;
        stat.empty      = !rd_used_reg;
        stat.last       = (pcnt_reg == SLOT_W'(TABLE_SLOTS - 1));
        stat.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - RES_BITS){1'b0}}, out_data_reg};

endmodule

/* sv/hksl_ctrl.sv */
// ============================================================================
// hksl_ctrl: request sequencer of the hashed key set
// Runs the clear sweep after reset, then steps each request through the
// hash sequence and the linear probe, and hands the result to the datapath.
// ============================================================================
module hksl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  hksl_pkg::hksl_stat_t stat,
    output hksl_pkg::hksl_cmd_t  cmd
);
    import hksl_pkg::*;

    hksl_state_t state_reg;
    hksl_state_t state_next;
    logic        probe_done;

    assign probe_done = stat.hit || stat.empty || stat.last;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (stat.clear_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_H1_LL;
            ST_H1_LL: state_next = ST_H1_HL;
            ST_H1_HL: state_next = ST_H1_LH;
            ST_H1_LH: state_next = ST_MIX;
            ST_MIX:   state_next = ST_H2_LL;
            ST_H2_LL: state_next = ST_H2_HL;
            ST_H2_HL: state_next = ST_H2_LH;
            ST_H2_LH: state_next = ST_HOME;
            ST_HOME:  state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: begin
                if (!probe_done) begin
                    state_next = ST_READ;
                end else if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        cmd          = '0;
        cmd.op       = OP_NONE;
        s_tready     = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clear = 1'b1;
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_H1_LL: cmd.op = OP_MUL_LL;
            ST_H1_HL: cmd.op = OP_MUL_HL;
            ST_H1_LH: cmd.op = OP_MUL_LH;
            ST_MIX:   cmd.op = OP_MIX;
            ST_H2_LL: begin
                cmd.op       = OP_MUL_LL;
                cmd.mul_fmix = 1'b1;
            end
            ST_H2_HL: begin
                cmd.op       = OP_MUL_HL;
                cmd.mul_fmix = 1'b1;
            end
            ST_H2_LH: begin
                cmd.op       = OP_MUL_LH;
                cmd.mul_fmix = 1'b1;
            end
            ST_HOME:  cmd.op = OP_HOME;
            ST_READ:  cmd.rd = 1'b1;
            ST_CHECK: begin
                cmd.step   = !probe_done;
                cmd.finish = probe_done && stat.out_free;
            end
            default: begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

/* sv/hashed_key_set_linear_probe.sv */
// ============================================================================
// hashed_key_set_linear_probe: fixed-size set of (device, inode) keys
// Open-addressing hash table with linear probing and a load limit.
// ============================================================================
// Usage:
//   s_ channel carries one request: s_tuser is the request type (0 = query,
//   1 = insert if absent), s_tdata holds device_id [63:0], inode_num [127:64].
//   m_ channel returns one result per request in m_tdata: was_present [0],
//   inserted [1], full_reject [2], upper bits zero.
// Sequence: after accept, the hash steps through H1_LL, H1_HL, H1_LH, MIX,
//   H2_LL, H2_HL, H2_LH and HOME, the partial products on one shared 32x32
//   multiplier; each of the 1 .. 1024 slots probed is a registered read of
//   the slot memory followed by a compare. One request is in flight at a
//   time, so the next is accepted only after the previous result is loaded.
// Reset: aresetn (synchronous, active low) starts a sweep over all 1024 slots
//   that clears the occupancy memory; s_tready stays low until it is done.
// Stall: the result sits in an output register, so the next request is
//   accepted and hashed while m_tready is low; it waits only at the end of
//   its probe until the output register frees up.
// ============================================================================
module hashed_key_set_linear_probe (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // device_id [63:0], inode_num [127:64]
    input  logic         s_tuser,   // req_type [0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata    // was_present [0], inserted [1], full_reject [2]
);
    import hksl_pkg::*;

    hksl_cmd_t  cmd;
    hksl_stat_t stat;

    // Sequencer
    hksl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hash, memories and result register
    hksl_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A result is only loaded when the output register is free
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> stat.out_free)
        else $error("result loaded over a pending result");

    // A finished probe always shows a result next cycle
    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("finished request produced no result");

    // An insert excludes both presence and refusal
    a_result_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[RES_INSERTED]) |-> (!m_tdata[RES_PRESENT] && !m_tdata[RES_REJECT]))
        else $error("inconsistent result flags");

    // No request is taken while a probe or the clear sweep is running
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.clear || cmd.rd || cmd.step) |-> !s_tready)
        else $error("request accepted while busy");

endmodule

/* bench/tb_top.sv */
// ============================================================================
// tb_top: self-checking bench for the hashed key set with linear probing
// Sends query and insert requests for (device, inode) keys, mirrors the
// table in a behavioral model and checks every result in order. The run
// fills the table to its load limit, probes long clustered chains with keys
// that share a half and a home slot with a stored key, and randomly stalls
// both channels, including one long result hold-off.
// ============================================================================
module tb_top;

    // Table geometry and hash constants of the mirror
    localparam int unsigned TABLE_SLOTS  = 1024;
    localparam logic [63:0] GOLDEN_MUL   = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] FINAL_MUL    = 64'hbf58_476d_1ce4_e5b9;

    // Run shape
    localparam int unsigned N_DIRECTED   = 18;
    localparam int unsigned N_RANDOM     = 1680;
    localparam int unsigned PRESSURE_AT  = 300;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 2100;
    localparam int unsigned SEARCH_TRIES = 8192;
    localparam longint      WATCHDOG     = 80_000_000;

    typedef enum bit {
        REQ_QUERY  = 1'b0,
        REQ_INSERT = 1'b1
    } req_t;

    typedef struct packed {
        bit was_present;
        bit inserted;
        bit full_reject;
    } hk_result_t;

    localparam hk_result_t R_ABSENT = '{was_present: 1'b0, inserted: 1'b0, full_reject: 1'b0};
    localparam hk_result_t R_ADDED  = '{was_present: 1'b0, inserted: 1'b1, full_reject: 1'b0};
    localparam hk_result_t R_FOUND  = '{was_present: 1'b1, inserted: 1'b0, full_reject: 1'b0};

    typedef struct packed {
        req_t        req;
        logic [63:0] dev;
        logic [63:0] ino;
        hk_result_t  want;
    } dir_row_t;

    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] MSB  = 64'h8000_0000_0000_0000;

    // Directed requests, all on a nearly empty table
    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{REQ_QUERY,  64'h0, 64'h0, R_ABSENT},
        '{REQ_INSERT, 64'h0, 64'h0, R_ADDED},
        '{REQ_QUERY,  64'h0, 64'h0, R_FOUND},
        '{REQ_INSERT, 64'h0, 64'h0, R_FOUND},
        '{REQ_QUERY,  ONES,  ONES,  R_ABSENT},
        '{REQ_INSERT, ONES,  ONES,  R_ADDED},
        '{REQ_INSERT, ONES,  ONES,  R_FOUND},
        '{REQ_QUERY,  ONES,  ONES,  R_FOUND},
        '{REQ_QUERY,  64'h0, ONES,  R_ABSENT},
        '{REQ_QUERY,  ONES,  64'h0, R_ABSENT},
        '{REQ_INSERT, 64'h0, ONES,  R_ADDED},
        '{REQ_INSERT, ONES,  64'h0, R_ADDED},
        '{REQ_QUERY,  64'h1, 64'h0, R_ABSENT},
        '{REQ_INSERT, MSB,   64'h1, R_ADDED},
        '{REQ_QUERY,  MSB,   64'h1, R_FOUND},
        '{REQ_INSERT, 64'h0000_dead_0000_beef, 64'h1234_5678_9abc_def0, R_ADDED},
        '{REQ_QUERY,  64'h0, 64'h0, R_FOUND},
        '{REQ_QUERY,  64'h1, MSB,   R_ABSENT}
    };

    // DUT interface
    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // device_id [63:0], inode_num [127:64]
    logic         s_tuser;   // req_type [0]
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;   // was_present [0], inserted [1], full_reject [2]

    // Mirror of the key table
    logic [63:0]  mirror_dev  [TABLE_SLOTS];
    logic [63:0]  mirror_ino  [TABLE_SLOTS];
    bit           mirror_used [TABLE_SLOTS];
    int unsigned  mirror_count;

    hk_result_t   pending_results [$];
    logic [127:0] known_keys [$];      // every key ever offered for insert
    int unsigned  accepted;
    int unsigned  tx_calm_left;
    int unsigned  error_count;
    bit           hold_off_req;
    bit           hold_off_done;

    hashed_key_set_linear_probe i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Mixing hash: golden-ratio multiply, then xor-shift/multiply finalizer
    function automatic logic [63:0] key_hash(input logic [63:0] dev, input logic [63:0] ino);
        logic [63:0] h;
        h = (dev * GOLDEN_MUL) ^ ino;
        h = h ^ (h >> 30);
        h = h * FINAL_MUL;
        h = h ^ (h >> 27);
        return h ^ (h >> 31);
    endfunction

    function automatic int unsigned home_of(input logic [63:0] dev, input logic [63:0] ino);
        return int'(key_hash(dev, ino) & 64'(TABLE_SLOTS - 1));
    endfunction

    // Probe the mirror, store an absent key on insert below the load limit
    function automatic hk_result_t predict_set_access(input req_t req, input logic [63:0] dev,
                                                      input logic [63:0] ino);
        hk_result_t  res;
        int unsigned idx;
        int unsigned n;
        bit          found;
        bit          have_free;
        res       = R_ABSENT;
        found     = 1'b0;
        have_free = 1'b0;
        idx       = home_of(dev, ino);
        for (n = 0; n < TABLE_SLOTS && !found && !have_free; n++) begin
            if (!mirror_used[idx]) begin
                have_free = 1'b1;
            end else if (mirror_dev[idx] == dev && mirror_ino[idx] == ino) begin
                found = 1'b1;
            end else begin
                idx = (idx + 1) % TABLE_SLOTS;
            end
        end
        res.was_present = found;
        if (req == REQ_INSERT && !found) begin
            if ((mirror_count + 1) * 10 >= TABLE_SLOTS * 7 || !have_free) begin
                res.full_reject = 1'b1;
            end else begin
                mirror_dev[idx]  = dev;
                mirror_ino[idx]  = ino;
                mirror_used[idx] = 1'b1;
                mirror_count++;
                res.inserted = 1'b1;
            end
        end
        return res;
    endfunction

    // Offer one request after a random idle gap; predict once it is taken
    task automatic offer_request(input req_t req, input logic [63:0] dev, input logic [63:0] ino,
                                 input bit typed, input hk_result_t typed_want);
        hk_result_t  predicted;
        int unsigned gap;
        int unsigned roll;
        gap  = 0;
        roll = $urandom_range(99);
        if (tx_calm_left > 0) begin
            tx_calm_left--;
        end else if (roll < 3) begin
            tx_calm_left = $urandom_range(20, 80);
        end else if (roll < 30) begin
            gap = $urandom_range(1, 3);
        end else if (roll < 38) begin
            gap = $urandom_range(4, 12);
        end else if (roll < 40) begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {ino, dev};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_set_access(req, dev, ino);
        pending_results.push_back(typed ? typed_want : predicted);
        if (req == REQ_INSERT) known_keys.push_back({ino, dev});
        accepted++;
        if (accepted == PRESSURE_AT) hold_off_req = 1'b1;
    endtask

    // Stimulus: reset, directed table, then random traffic
    initial begin : request_gen
        req_t         req;
        logic [63:0]  dev;
        logic [63:0]  ino;
        logic [127:0] base;
        int unsigned  target;
        int unsigned  roll;
        int unsigned  tries;
        bit           keep_dev;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        mirror_count  = 0;
        accepted      = 0;
        tx_calm_left  = 0;
        error_count   = 0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            offer_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].dev, DIRECTED_ROWS[i].ino,
                          1'b1, DIRECTED_ROWS[i].want);
        end

        // Mostly fresh inserts, past the load limit, plus hits and near misses
        for (int i = 0; i < N_RANDOM; i++) begin
            roll = $urandom_range(99);
            base = known_keys[$urandom_range(known_keys.size() - 1)];
            if (roll < 55 || (roll >= 77 && roll < 85)) begin
                req = (roll < 55) ? REQ_INSERT : REQ_QUERY;
                dev = ($urandom_range(3) == 0) ? 64'($urandom_range(255)) : {$urandom, $urandom};
                ino = ($urandom_range(3) == 0) ? 64'($urandom_range(255)) : {$urandom, $urandom};
            end else if (roll < 77) begin
                req = (roll < 65) ? REQ_INSERT : REQ_QUERY;
                dev = base[63:0];
                ino = base[127:64];
            end else begin
                // shares one half with a stored key and lands on its home slot
                target   = home_of(base[63:0], base[127:64]);
                keep_dev = $urandom_range(1);
                for (tries = 0; tries < SEARCH_TRIES; tries++) begin
                    dev = keep_dev ? base[63:0] : {$urandom, $urandom};
                    ino = keep_dev ? {$urandom, $urandom} : base[127:64];
                    if (home_of(dev, ino) == target) break;
                end
                req = req_t'($urandom_range(1));
            end
            offer_request(req, dev, ino, 1'b0, R_ABSENT);
        end
        s_tvalid <= 1'b0;

        // Drain
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("** hashed_key_set_linear_probe: PASSED **");
        end else begin
            $display("** hashed_key_set_linear_probe: FAILED **");
        end
        $finish;
    end

    // Result ready: random stalls, calm stretches, one long hold-off
    initial begin : ready_gen
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned roll;
        m_tready   = 1'b0;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if (calm_left > 0) begin
                calm_left--;
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                roll = $urandom_range(99);
                m_tready <= 1'b1;
                if (roll < 3) begin
                    calm_left = $urandom_range(30, 120);
                end else if (roll < 25) begin
                    stall_left = $urandom_range(1, 3);
                end else if (roll < 30) begin
                    stall_left = $urandom_range(8, 40);
                end
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge aclk) begin : result_check
        hk_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got m_tdata %h",
                         $time, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.was_present) begin
                    $display("%0t: was_present expected %0b got %0b",
                             $time, want.was_present, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[1] !== want.inserted) begin
                    $display("%0t: inserted expected %0b got %0b",
                             $time, want.inserted, m_tdata[1]);
                    error_count++;
                end
                if (m_tdata[2] !== want.full_reject) begin
                    $display("%0t: full_reject expected %0b got %0b",
                             $time, want.full_reject, m_tdata[2]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #(WATCHDOG);
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("** hashed_key_set_linear_probe: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
sv/hksl_pkg.sv
sv/hksl_datapath.sv
sv/hksl_ctrl.sv
sv/hashed_key_set_linear_probe.sv
bench/tb_top.sv
